// ===== sv/qrv_pkg.sv =====
// Package with the item types and constants of the quaternion vector rotation core.
`timescale 1ns / 1ps

package qrv_pkg;

   localparam int QUAT_WIDTH         = 16;
   localparam int QUAT_FRAC_BITS_DEF = 14;
   localparam int VEC_WIDTH          = 32;
   localparam int VEC_LO             = VEC_WIDTH / 2;
   localparam int VEC_HI             = VEC_WIDTH - VEC_LO;

   localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                          action;
      logic signed [QUAT_WIDTH-1:0]  quat_x;
      logic signed [QUAT_WIDTH-1:0]  quat_y;
      logic signed [QUAT_WIDTH-1:0]  quat_z;
      logic signed [QUAT_WIDTH-1:0]  quat_w;
      logic signed [VEC_WIDTH-1:0]   vec_x;
      logic signed [VEC_WIDTH-1:0]   vec_y;
      logic signed [VEC_WIDTH-1:0]   vec_z;
   } qrv_req_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0]   out_x;
      logic signed [VEC_WIDTH-1:0]   out_y;
      logic signed [VEC_WIDTH-1:0]   out_z;
   } qrv_rsp_type;

endpackage

// ===== sv/quaternion_rotate_vector_core.sv =====
// Pipelined core that rotates a fixed-point vector by the matrix of a quaternion or its transpose.
`timescale 1ns / 1ps

// Channel    Ports                        Handshake
// request    start, busy, req_data        taken at a clock edge with start high, busy low
// response   rsp_valid, rsp_data          one-cycle strobe, no back pressure
//
// Six register stages: quaternion products, matrix entries, partial products,
// entry-vector products, row sums with rounding, saturation into the output.
// A new item can be taken in every cycle while busy is low, and its result leaves from the last stage.
// The third stage splits each product into multipliers of at most 18 by 17 bits,
// and the fourth stage holds the wide adds that combine them.
// Reset clears the valid bits; busy is set by reset and cleared at the first clock edge without reset.
// The pipeline never stalls since the receiver takes every result.

module quaternion_rotate_vector_core
   import qrv_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  qrv_req_type req_data,
   output logic        rsp_valid,
   output qrv_rsp_type rsp_data
);

   localparam int FRAC2  = 2 * QUAT_FRAC_BITS;
   localparam int MAT_W  = ((FRAC2 > 32) ? FRAC2 : 32) + 3;
   localparam int LO_M   = MAT_W / 2;
   localparam int HI_M   = MAT_W - LO_M;
   localparam int PROD_W = MAT_W + VEC_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SH_W   = ACC_W - FRAC2;
   localparam int STAGES = 6;

   localparam logic signed [MAT_W-1:0] ONE  = MAT_W'(1) << FRAC2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC2 - 1);

   logic              busy_ff;
   logic [STAGES-1:0] valid_ff;

   // Stage 1: products of quaternion components.
   logic signed [2*QUAT_WIDTH-1:0] xx_ff, yy_ff, zz_ff, xy_ff, wz_ff;
   logic signed [2*QUAT_WIDTH-1:0] wy_ff, xz_ff, yz_ff, wx_ff;
   logic                           action1_ff;
   logic signed [VEC_WIDTH-1:0]    vec1_ff [3];

   // Stage 2: matrix entries, transposed for the inverse when action is set.
   logic signed [MAT_W-1:0]        r_mat [3][3];
   logic signed [MAT_W-1:0]        mat_in [3][3];
   logic signed [MAT_W-1:0]        mat_ff [3][3];
   logic signed [VEC_WIDTH-1:0]    vec2_ff [3];

   // Stage 3 and 4: partial products and full entry-vector products.
   logic        [LO_M+VEC_LO-1:0]   ll_ff [3][3];
   logic signed [LO_M+VEC_HI:0]     lh_ff [3][3];
   logic signed [HI_M+VEC_LO:0]     hl_ff [3][3];
   logic signed [HI_M+VEC_HI-1:0]   hh_ff [3][3];
   logic signed [PROD_W-1:0]        prod_ff [3][3];

   // Stage 5 and 6: rounded row sums and saturated results.
   logic signed [ACC_W-1:0]         acc_ff [3];
   logic signed [VEC_WIDTH-1:0]     sat_in [3];
   qrv_rsp_type                     rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= {valid_ff[STAGES-2:0], start && !busy_ff};
      end
   end

   always_ff @(posedge clock) begin
      xx_ff      <= req_data.quat_x * req_data.quat_x;
      yy_ff      <= req_data.quat_y * req_data.quat_y;
      zz_ff      <= req_data.quat_z * req_data.quat_z;
      xy_ff      <= req_data.quat_x * req_data.quat_y;
      wz_ff      <= req_data.quat_w * req_data.quat_z;
      wy_ff      <= req_data.quat_w * req_data.quat_y;
      xz_ff      <= req_data.quat_x * req_data.quat_z;
      yz_ff      <= req_data.quat_y * req_data.quat_z;
      wx_ff      <= req_data.quat_w * req_data.quat_x;
      action1_ff <= req_data.action;
      vec1_ff[0] <= req_data.vec_x;
      vec1_ff[1] <= req_data.vec_y;
      vec1_ff[2] <= req_data.vec_z;
   end

   assign r_mat[0][0] = ONE - ((MAT_W'(yy_ff) + MAT_W'(zz_ff)) <<< 1);
   assign r_mat[0][1] = (MAT_W'(xy_ff) - MAT_W'(wz_ff)) <<< 1;
   assign r_mat[0][2] = (MAT_W'(wy_ff) + MAT_W'(xz_ff)) <<< 1;
   assign r_mat[1][0] = (MAT_W'(xy_ff) + MAT_W'(wz_ff)) <<< 1;
   assign r_mat[1][1] = ONE - ((MAT_W'(xx_ff) + MAT_W'(zz_ff)) <<< 1);
   assign r_mat[1][2] = (MAT_W'(yz_ff) - MAT_W'(wx_ff)) <<< 1;
   assign r_mat[2][0] = (MAT_W'(xz_ff) - MAT_W'(wy_ff)) <<< 1;
   assign r_mat[2][1] = (MAT_W'(wx_ff) + MAT_W'(yz_ff)) <<< 1;
   assign r_mat[2][2] = ONE - ((MAT_W'(xx_ff) + MAT_W'(yy_ff)) <<< 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat_in[i][j] = action1_ff ? r_mat[j][i] : r_mat[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      mat_ff  <= mat_in;
      vec2_ff <= vec1_ff;
   end

   // Each entry and vector component is cut in halves; the low halves are
   // unsigned, so they get a zero bit before the signed multiplies.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         logic        [LO_M-1:0]   m_lo;
         logic signed [HI_M-1:0]   m_hi;
         logic        [VEC_LO-1:0] v_lo;
         logic signed [VEC_HI-1:0] v_hi;

         assign m_lo = mat_ff[i][j][LO_M-1:0];
         assign m_hi = mat_ff[i][j][MAT_W-1:LO_M];
         assign v_lo = vec2_ff[j][VEC_LO-1:0];
         assign v_hi = vec2_ff[j][VEC_WIDTH-1:VEC_LO];

         always_ff @(posedge clock) begin
            ll_ff[i][j]   <= m_lo * v_lo;
            lh_ff[i][j]   <= $signed({1'b0, m_lo}) * v_hi;
            hl_ff[i][j]   <= m_hi * $signed({1'b0, v_lo});
            hh_ff[i][j]   <= m_hi * v_hi;
            // The high-high and low-low terms do not overlap and are joined.
            prod_ff[i][j] <= $signed({hh_ff[i][j], ll_ff[i][j]})
                             + (PROD_W'(lh_ff[i][j]) <<< VEC_LO)
                             + (PROD_W'(hl_ff[i][j]) <<< LO_M);
         end
      end

      always_ff @(posedge clock) begin
         acc_ff[i] <= ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1])
                      + ACC_W'(prod_ff[i][2]) + HALF;
      end

      logic signed [SH_W-1:0]         sh;
      logic        [SH_W-VEC_WIDTH:0] top;

      assign sh  = acc_ff[i][ACC_W-1:FRAC2];
      assign top = sh[SH_W-1:VEC_WIDTH-1];

      always_comb begin
         if ((&top) || !(|top)) begin
            sat_in[i] = sh[VEC_WIDTH-1:0];
         end else if (sh[SH_W-1]) begin
            sat_in[i] = VEC_MIN;
         end else begin
            sat_in[i] = VEC_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.out_x <= sat_in[0];
      rsp_ff.out_y <= sat_in[1];
      rsp_ff.out_z <= sat_in[2];
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

   // Every accepted item gives a result strobe once it has passed all pipeline stages.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(STAGES) rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, STAGES))
      else $error("result strobe without an accepted item");

   // A zero quaternion gives the identity matrix, so the vector comes back unchanged.
   a_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.quat_x == '0 && req_data.quat_y == '0
                          && req_data.quat_z == '0 && req_data.quat_w == '0, STAGES))
      |-> (rsp_data.out_x == $past(req_data.vec_x, STAGES)
           && rsp_data.out_y == $past(req_data.vec_y, STAGES)
           && rsp_data.out_z == $past(req_data.vec_z, STAGES)))
      else $error("identity rotation changed the vector");

endmodule
